// File: hw/rtl/sot_pkg.sv
package sot_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE      = 3'd0,
    REQ_ACQUIRE     = 3'd1,
    REQ_SIGNAL      = 3'd2,
    REQ_RESET       = 3'd3,
    REQ_REL_MUTEX   = 3'd4,
    REQ_REL_SEMA    = 3'd5
  } req_code_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EVENT   = 3'd0,
    KIND_SEMA    = 3'd1,
    KIND_MUTEX   = 3'd2,
    KIND_PROCESS = 3'd3,
    KIND_THREAD  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_SLOT = 2'd2
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [SLOT_W-1:0]        slot;
    logic [KIND_W-1:0]        obj_kind;
    logic                     manual_mode;
    logic                     initial_signal;
    logic signed [DATA_W-1:0] amount;
    logic [DATA_W-1:0]        create_owner;
    logic [DATA_W-1:0]        requester_id;
    logic                     process_exited;
  } req_t;

  typedef struct packed {
    logic                     acquired;
    logic [SLOT_W-1:0]        new_slot;
    logic signed [DATA_W-1:0] old_count;
    logic [STATUS_W-1:0]      status;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     manual;
    logic                     signalled;
    logic signed [DATA_W-1:0] count;
    logic [DATA_W-1:0]        owner;
    logic [DATA_W-1:0]        depth;
  } entry_t;

  localparam logic signed [DATA_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] COUNT_MIN = 32'sh8000_0000;
  localparam logic [DATA_W-1:0]        DEPTH_MAX = 32'hFFFF_FFFF;

endpackage

// File: hw/rtl/sot_if.sv
interface sot_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  slot;
  logic [2:0]  obj_kind;
  logic        manual_mode;
  logic        initial_signal;
  logic signed [31:0] amount;
  logic [31:0] create_owner;
  logic [31:0] requester_id;
  logic        process_exited;

  modport source (
    output valid, req_type, slot, obj_kind, manual_mode, initial_signal, amount,
           create_owner, requester_id, process_exited,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, obj_kind, manual_mode, initial_signal, amount,
           create_owner, requester_id, process_exited,
    output ready
  );
endinterface

interface sot_rsp_if;
  logic        valid;
  logic        ready;
  logic        acquired;
  logic [5:0]  new_slot;
  logic signed [31:0] old_count;
  logic [1:0]  status;

  modport source (
    output valid, acquired, new_slot, old_count, status,
    input  ready
  );
  modport sink (
    input  valid, acquired, new_slot, old_count, status,
    output ready
  );
endinterface

// File: hw/rtl/sot_store.sv
module sot_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sot_pkg::entry_t wr_data,
  output sot_pkg::entry_t rd_data
);

  sot_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// File: hw/rtl/sot_exec.sv
module sot_exec #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned AW = $clog2(SLOTS),
  localparam int unsigned CW = $clog2(SLOTS + 1)
) (
  input  sot_pkg::req_t   req,
  input  logic [AW-1:0]   idx,
  input  sot_pkg::entry_t cur,
  input  logic [CW-1:0]   next_free,
  output sot_pkg::rsp_t   res,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output sot_pkg::entry_t wr_data,
  output logic            create_ok
);

  logic              known;
  logic              full;
  logic signed [32:0] sum;

  assign known = 32'(req.slot) < 32'(next_free);
  assign full  = 32'(next_free) >= SLOTS;
  assign sum   = {cur.count[31], cur.count} + {req.amount[31], req.amount};

  always_comb begin
    res       = '0;
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = cur;
    create_ok = 1'b0;
    case (req.req_type)
      sot_pkg::REQ_CREATE: begin
        if (full) begin
          res.status = sot_pkg::ST_FULL;
        end else begin
          create_ok         = 1'b1;
          wr_en             = 1'b1;
          wr_addr           = next_free[AW-1:0];
          wr_data.kind      = req.obj_kind;
          wr_data.manual    = req.manual_mode;
          wr_data.signalled = req.initial_signal;
          wr_data.count     = req.amount;
          wr_data.owner     = req.create_owner;
          wr_data.depth     = '0;
          res.new_slot      = sot_pkg::SLOT_W'(next_free);
        end
      end
      sot_pkg::REQ_ACQUIRE, sot_pkg::REQ_SIGNAL, sot_pkg::REQ_RESET,
      sot_pkg::REQ_REL_MUTEX, sot_pkg::REQ_REL_SEMA: begin
        if (!known) begin
          res.status   = sot_pkg::ST_NO_SLOT;
          res.acquired = (req.req_type == sot_pkg::REQ_ACQUIRE);
        end else begin
          wr_en = 1'b1;
          case (req.req_type)
            sot_pkg::REQ_ACQUIRE: begin
              case (cur.kind)
                sot_pkg::KIND_EVENT: begin
                  res.acquired = cur.signalled;
                  if (!cur.manual) begin
                    wr_data.signalled = 1'b0;
                  end
                end
                sot_pkg::KIND_SEMA: begin
                  res.acquired = cur.count > 0;
                  if (cur.count > 0) begin
                    wr_data.count = cur.count - 32'sd1;
                  end
                end
                sot_pkg::KIND_MUTEX: begin
                  if ((cur.owner == '0) || (cur.owner == req.requester_id)) begin
                    res.acquired  = 1'b1;
                    wr_data.owner = req.requester_id;
                    if (cur.depth != sot_pkg::DEPTH_MAX) begin
                      wr_data.depth = cur.depth + 32'd1;
                    end
                  end
                end
                sot_pkg::KIND_PROCESS: begin
                  res.acquired = cur.signalled || req.process_exited;
                end
                default: begin
                  res.acquired = cur.signalled;
                end
              endcase
            end
            sot_pkg::REQ_SIGNAL: begin
              wr_data.signalled = 1'b1;
            end
            sot_pkg::REQ_RESET: begin
              wr_data.signalled = 1'b0;
            end
            sot_pkg::REQ_REL_MUTEX: begin
              if (cur.depth <= 32'd1) begin
                wr_data.depth = '0;
                wr_data.owner = '0;
              end else begin
                wr_data.depth = cur.depth - 32'd1;
              end
            end
            default: begin
              res.old_count = cur.count;
              if (sum[32] != sum[31]) begin
                wr_data.count = sum[32] ? sot_pkg::COUNT_MIN : sot_pkg::COUNT_MAX;
              end else begin
                wr_data.count = sum[31:0];
              end
            end
          endcase
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/sync_object_table_unit.sv
// Channel  Direction  Contents
// req      in         request type, slot and create or release arguments
// rsp      out        acquired flag, allocated slot, previous count, status
//
// A request is registered on acceptance together with a read of its table entry; once the
// response register is free, the result is worked out, the entry written back and the response
// register loaded, so one request can enter each cycle while rsp.ready stays high.
// The single table memory, with a bypass from its write port, sets that rate.
// Reset clears the valid flags and the allocation counter; table contents need no clearing.
// While a response waits, one further request is taken and held before the input stalls.
module sync_object_table_unit #(
  parameter int unsigned SLOTS = 64
) (
  input logic     clk,
  input logic     rst,
  sot_req_if.sink   req,
  sot_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic            in_ready;
  logic            out_free;
  logic            s1_adv;
  logic            s1_valid;
  sot_pkg::req_t   s1_req;
  logic [AW-1:0]   s1_idx;
  logic [AW-1:0]   in_idx;
  logic            out_valid;
  sot_pkg::rsp_t   out_rsp;
  logic [CW-1:0]   next_free;
  sot_pkg::entry_t cur;
  sot_pkg::rsp_t   res;
  logic            ex_wr_en;
  logic [AW-1:0]   wr_addr;
  sot_pkg::entry_t wr_data;
  logic            create_ok;

  generate
    if (AW > sot_pkg::SLOT_W) begin : g_wide
      assign in_idx = {{(AW - sot_pkg::SLOT_W){1'b0}}, req.slot};
    end else begin : g_narrow
      assign in_idx = req.slot[AW-1:0];
    end
  endgenerate

  assign out_free  = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign req.ready = in_ready;

  sot_store #(.DEPTH(SLOTS)) u_store (
    .clk     (clk),
    .rd_en   (req.valid && in_ready),
    .rd_addr (in_idx),
    .wr_en   (s1_adv && ex_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (cur)
  );

  sot_exec #(.SLOTS(SLOTS)) u_exec (
    .req       (s1_req),
    .idx       (s1_idx),
    .cur       (cur),
    .next_free (next_free),
    .res       (res),
    .wr_en     (ex_wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .create_ok (create_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      next_free <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= req.valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv && create_ok) begin
        next_free <= next_free + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      s1_req.req_type       <= req.req_type;
      s1_req.slot           <= req.slot;
      s1_req.obj_kind       <= req.obj_kind;
      s1_req.manual_mode    <= req.manual_mode;
      s1_req.initial_signal <= req.initial_signal;
      s1_req.amount         <= req.amount;
      s1_req.create_owner   <= req.create_owner;
      s1_req.requester_id   <= req.requester_id;
      s1_req.process_exited <= req.process_exited;
      s1_idx                <= in_idx;
    end
    if (s1_adv) begin
      out_rsp <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.acquired  = out_rsp.acquired;
  assign rsp.new_slot  = out_rsp.new_slot;
  assign rsp.old_count = out_rsp.old_count;
  assign rsp.status    = out_rsp.status;

endmodule
